[hw/rtl/tin_pkg.sv]
`default_nettype none

package tin_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 12;

    localparam int CH_W    = 8;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 12;
    localparam int KIND_W  = 2;
    localparam int DIGIT_W = 4;

    localparam logic [LEN_W-1:0] LEN_MAX = 12'hFFF;
    localparam logic [LEN_W-1:0] LEN_ONE = 12'h001;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [CH_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CH_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [CH_W-1:0] CH_VTAB       = 8'h0B;
    localparam logic [CH_W-1:0] CH_FORMFEED   = 8'h0C;
    localparam logic [CH_W-1:0] CH_RETURN     = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CH_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CH_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CH_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_Z    = 8'h7A;

    typedef enum logic [KIND_W-1:0] {
        KIND_NUMBER = 2'd0,
        KIND_IDENT  = 2'd1,
        KIND_OTHER  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_NUMBER = 3'b010,
        MODE_IDENT  = 3'b100
    } t_mode;

    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

    function automatic int data_w(int ob, int lb, int cb);
        return ((VALUE_W + ob + lb + cb + LEN_W + 7) / 8) * 8;
    endfunction

    function automatic logic is_decimal(logic [CH_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(logic [CH_W-1:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic is_space(logic [CH_W-1:0] c);
        return (c == CH_TAB) || (c == CH_NEWLINE) || (c == CH_VTAB) ||
               (c == CH_FORMFEED) || (c == CH_RETURN) || (c == CH_SPACE);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/tin_step.sv]
`default_nettype none

module tin_step #(
    parameter int OFFSET_BITS = tin_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = tin_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = tin_pkg::COLUMN_BITS_DEF,
    parameter int ENTRY_W     = tin_pkg::data_w(OFFSET_BITS, LINE_BITS, COLUMN_BITS)
                                + tin_pkg::KIND_W + 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_fire,
    input  wire logic [tin_pkg::CH_W-1:0]  i_ch,
    input  wire logic                      i_last,
    output tin_pkg::t_push                 o_push,
    output logic [ENTRY_W-1:0]             o_entry0,
    output logic [ENTRY_W-1:0]             o_entry1
);
    import tin_pkg::*;

    localparam int RAW_W  = VALUE_W + OFFSET_BITS + LINE_BITS + COLUMN_BITS + LEN_W;
    localparam int DATA_W = data_w(OFFSET_BITS, LINE_BITS, COLUMN_BITS);

    t_mode                  r_mode, n_mode;
    logic [VALUE_W-1:0]     r_acc, n_acc;
    logic [OFFSET_BITS-1:0] r_start_off, n_start_off;
    logic [LINE_BITS-1:0]   r_start_line, n_start_line;
    logic [COLUMN_BITS-1:0] r_start_col, n_start_col;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;

    logic [CH_W-1:0]    w_dsub;
    logic [DIGIT_W-1:0] w_digit;
    logic [VALUE_W-1:0] w_acc10;
    logic [LEN_W-1:0]   w_len_inc;
    logic               w_dig, w_let, w_us, w_sp;
    logic               w_cont, w_end_open, w_other, w_final;
    logic [ENTRY_W-1:0] w_e_other, w_e_fin, w_second;

    function automatic logic [ENTRY_W-1:0] pack_entry(
        t_kind                  kind,
        logic [VALUE_W-1:0]     value,
        logic [OFFSET_BITS-1:0] off,
        logic [LINE_BITS-1:0]   line,
        logic [COLUMN_BITS-1:0] col,
        logic [LEN_W-1:0]       len,
        logic                   last
    );
        logic [DATA_W-1:0] d;
        d            = '0;
        d[RAW_W-1:0] = {len, col, line, off, value};
        return {last, kind, d};
    endfunction

    function automatic t_kind kind_of(t_mode m);
        return (m == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
    endfunction

    assign w_dig     = is_decimal(i_ch);
    assign w_let     = is_alpha(i_ch);
    assign w_us      = (i_ch == CH_UNDERSCORE);
    assign w_sp      = is_space(i_ch);
    assign w_dsub    = i_ch - CH_ZERO;
    assign w_digit   = w_dsub[DIGIT_W-1:0];
    assign w_acc10   = {r_acc[VALUE_W-4:0], 3'b000} + {r_acc[VALUE_W-2:0], 1'b0}
                       + {{(VALUE_W-DIGIT_W){1'b0}}, w_digit};
    assign w_len_inc = (r_len == LEN_MAX) ? r_len : r_len + LEN_ONE;

    always_comb begin
        n_mode       = r_mode;
        n_acc        = r_acc;
        n_start_off  = r_start_off;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        n_len        = r_len;
        w_end_open   = 1'b0;
        w_other      = 1'b0;

        unique case (r_mode)
            MODE_NUMBER: w_cont = w_dig;
            MODE_IDENT:  w_cont = w_let | w_dig | w_us;
            default:     w_cont = 1'b0;
        endcase

        if (w_cont) begin
            if (r_mode == MODE_NUMBER) begin
                n_acc = w_acc10;
            end
            n_len = w_len_inc;
        end else begin
            w_end_open = (r_mode == MODE_NUMBER) || (r_mode == MODE_IDENT);
            n_mode     = MODE_IDLE;
            n_acc      = '0;
            n_len      = '0;
            if (w_let || w_dig) begin
                n_mode       = w_let ? MODE_IDENT : MODE_NUMBER;
                n_acc        = w_let ? '0 : {{(VALUE_W-DIGIT_W){1'b0}}, w_digit};
                n_start_off  = r_off;
                n_start_line = r_line;
                n_start_col  = r_col;
                n_len        = LEN_ONE;
            end else if (!w_sp) begin
                w_other = 1'b1;
            end
        end

        n_off = r_off + 1'b1;
        if (i_ch == CH_NEWLINE) begin
            n_line = r_line + 1'b1;
            n_col  = '0;
        end else begin
            n_line = r_line;
            n_col  = r_col + 1'b1;
        end

        w_final = i_last && (n_mode != MODE_IDLE);
        w_e_fin = pack_entry(kind_of(n_mode), (n_mode == MODE_NUMBER) ? n_acc : '0,
                             n_start_off, n_start_line, n_start_col, n_len, 1'b1);

        if (i_last) begin
            n_off  = '0;
            n_line = '0;
            n_col  = '0;
            if (w_final) begin
                n_mode = MODE_IDLE;
                n_acc  = '0;
                n_len  = '0;
            end
        end
    end

    assign w_e_other = pack_entry(KIND_OTHER, '0, r_off, r_line, r_col, LEN_ONE, 1'b1);
    assign w_second  = w_other ? w_e_other : w_e_fin;

    assign o_push.push0 = i_fire && (w_end_open || w_other || w_final);
    assign o_push.push1 = i_fire && w_end_open && (w_other || w_final);
    assign o_entry0     = w_end_open
                          ? pack_entry(kind_of(r_mode),
                                       (r_mode == MODE_NUMBER) ? r_acc : '0,
                                       r_start_off, r_start_line, r_start_col, r_len,
                                       !(w_other || w_final))
                          : w_second;
    assign o_entry1     = w_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_acc        <= '0;
            r_start_off  <= '0;
            r_start_line <= '0;
            r_start_col  <= '0;
            r_len        <= '0;
            r_off        <= '0;
            r_line       <= '0;
            r_col        <= '0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_acc        <= n_acc;
            r_start_off  <= n_start_off;
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
            r_len        <= n_len;
            r_off        <= n_off;
            r_line       <= n_line;
            r_col        <= n_col;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tin_outq.sv]
`default_nettype none

module tin_outq #(
    parameter int ENTRY_W = tin_pkg::data_w(tin_pkg::OFFSET_BITS_DEF, tin_pkg::LINE_BITS_DEF,
                                            tin_pkg::COLUMN_BITS_DEF) + tin_pkg::KIND_W + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tin_pkg::t_push     i_push,
    input  wire logic [ENTRY_W-1:0] i_entry0,
    input  wire logic [ENTRY_W-1:0] i_entry1,
    output logic                    o_space,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [ENTRY_W-1:0]      o_entry
);
    import tin_pkg::*;

    logic [ENTRY_W-1:0] r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic [Q_PTR_W-1:0] w_wr1;
    logic               w_pop;

    assign w_wr1   = r_wr + 1'b1;
    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign o_space = (r_count <= Q_CNT_W'(Q_DEPTH - 2));

    assign n_wr    = r_wr + Q_PTR_W'(i_push.push0) + Q_PTR_W'(i_push.push1);
    assign n_count = r_count + Q_CNT_W'(i_push.push0) + Q_CNT_W'(i_push.push1)
                     - Q_CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_entry0;
        end
        if (i_push.push1) begin
            r_mem[w_wr1] <= i_entry1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_count <= n_count;
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue count beyond depth");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push1 |-> i_push.push0)
        else $error("second result pushed without first");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push0 |-> o_space)
        else $error("push into queue without room for two results");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.push0 && !w_pop) |=> (r_count != '0))
        else $error("queue empty right after a push");

endmodule

`default_nettype wire

[hw/rtl/identifier_number_tokenizer_unit.sv]
`default_nettype none

// Lexer for identifiers, decimal numbers and single-character tokens. One source byte
// is taken per cycle on the slave side while the result queue has room for two
// results (tlast marks the last byte of a text); each token leaves on the master side
// with its kind in tuser and value, start offset, line, column and length in tdata. A
// byte may close one token and produce another, so it can yield two results; the
// master side sends one result per cycle while tready is high, and a four-entry result
// queue decouples the two sides. A byte's first result passes the input register, then
// goes through the scanner into the queue. Bytes keep flowing as long as results drain;
// a byte that yields two results takes two output transfers.
module identifier_number_tokenizer_unit #(
    parameter int OFFSET_BITS = tin_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = tin_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = tin_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // ch
    input  wire logic [tin_pkg::CH_W-1:0]       i_s_tdata,
    input  wire logic                           i_s_tlast,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // number_value, start_offset, start_line, start_column, token_length, zero pad
    output logic [tin_pkg::data_w(OFFSET_BITS, LINE_BITS, COLUMN_BITS)-1:0] o_m_tdata,
    // kind
    output logic [tin_pkg::KIND_W-1:0]          o_m_tuser,
    output logic                                o_m_tlast,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready
);
    import tin_pkg::*;

    localparam int DATA_W  = data_w(OFFSET_BITS, LINE_BITS, COLUMN_BITS);
    localparam int ENTRY_W = DATA_W + KIND_W + 1;

    logic               r_in_valid;
    logic [CH_W-1:0]    r_in_ch;
    logic               r_in_last;
    logic               w_space;
    logic               w_fire;
    t_push              w_push;
    logic [ENTRY_W-1:0] w_entry0, w_entry1, w_head;

    assign w_fire     = r_in_valid && w_space;
    assign o_s_tready = !r_in_valid || w_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_ch   <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    tin_step #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_ch     (r_in_ch),
        .i_last   (r_in_last),
        .o_push   (w_push),
        .o_entry0 (w_entry0),
        .o_entry1 (w_entry1)
    );

    tin_outq #(
        .ENTRY_W (ENTRY_W)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry0 (w_entry0),
        .i_entry1 (w_entry1),
        .o_space  (w_space),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_entry  (w_head)
    );

    assign o_m_tdata = w_head[DATA_W-1:0];
    assign o_m_tuser = w_head[DATA_W +: KIND_W];
    assign o_m_tlast = w_head[ENTRY_W-1];

endmodule

`default_nettype wire

[tb/testbench.sv]
module testbench;
    import tin_pkg::*;

    localparam int OB = 16;
    localparam int LB = 16;
    localparam int CB = 12;
    localparam int DW = data_w(OB, LB, CB);
    localparam int OFF_LO = VALUE_W;
    localparam int LINE_LO = OFF_LO + OB;
    localparam int COL_LO = LINE_LO + LB;
    localparam int LEN_LO = COL_LO + CB;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PER_PHASE = 165;

    typedef struct {
        logic [CH_W-1:0] ch;
        logic            eot;
    } t_src_byte;

    typedef struct {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic [OB-1:0]      off;
        logic [LB-1:0]      line;
        logic [CB-1:0]      col;
        logic [LEN_W-1:0]   len;
        logic               last;
    } t_token;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic [CH_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic s_tvalid = 1'b0;
    logic m_tready = 1'b0;
    logic o_s_tready;
    logic [DW-1:0] o_m_tdata;
    logic [KIND_W-1:0] o_m_tuser;
    logic o_m_tlast;
    logic o_m_tvalid;

    t_src_byte byte_q[$];
    t_token tokens_due[$];
    int bytes_queued = 0;
    int send_idle = 21;
    int recv_idle = 45;
    int errors = 0;
    int cycles = 0;

    // lexer shadow state
    t_mode scan = MODE_IDLE;
    logic [VALUE_W-1:0] acc = '0;
    logic [OB-1:0] tok_off = '0;
    logic [LB-1:0] tok_line = '0;
    logic [CB-1:0] tok_col = '0;
    logic [LEN_W-1:0] tok_len = '0;
    logic [OB-1:0] cur_off = '0;
    logic [LB-1:0] cur_line = '0;
    logic [CB-1:0] cur_col = '0;

    identifier_number_tokenizer_unit #(
        .OFFSET_BITS(OB),
        .LINE_BITS(LB),
        .COLUMN_BITS(CB)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tdata(s_tdata),
        .i_s_tlast(s_tlast),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .o_m_tlast(o_m_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic dec_ch(logic [CH_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic alpha_ch(logic [CH_W-1:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic logic blank_ch(logic [CH_W-1:0] c);
        return c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB || c == CH_FORMFEED ||
               c == CH_RETURN || c == CH_SPACE;
    endfunction

    function automatic t_token close_token();
        t_token t;
        t.kind = (scan == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
        t.value = (scan == MODE_NUMBER) ? acc : '0;
        t.off = tok_off;
        t.line = tok_line;
        t.col = tok_col;
        t.len = tok_len;
        t.last = 1'b0;
        scan = MODE_IDLE;
        acc = '0;
        tok_len = '0;
        return t;
    endfunction

    function automatic void open_token(t_mode m);
        scan = m;
        acc = '0;
        tok_off = cur_off;
        tok_line = cur_line;
        tok_col = cur_col;
        tok_len = LEN_ONE;
    endfunction

    function automatic void lex_byte(logic [CH_W-1:0] c, logic eot);
        t_token res[2];
        int n;
        logic [DIGIT_W-1:0] dig;
        n = 0;
        dig = c[DIGIT_W-1:0];
        if (scan == MODE_NUMBER && dec_ch(c)) begin
            acc = VALUE_W'(acc * 10 + dig);
            if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
        end else if (scan == MODE_IDENT && (alpha_ch(c) || dec_ch(c) || c == CH_UNDERSCORE)) begin
            if (tok_len != LEN_MAX) tok_len = tok_len + 1'b1;
        end else begin
            if (scan != MODE_IDLE) begin
                res[n] = close_token();
                n++;
            end
            if (alpha_ch(c)) begin
                open_token(MODE_IDENT);
            end else if (dec_ch(c)) begin
                open_token(MODE_NUMBER);
                acc = VALUE_W'(dig);
            end else if (!blank_ch(c)) begin
                res[n] = '{kind: KIND_OTHER, value: '0, off: cur_off, line: cur_line,
                           col: cur_col, len: LEN_ONE, last: 1'b0};
                n++;
            end
        end
        cur_off = cur_off + 1'b1;
        if (c == CH_NEWLINE) begin
            cur_line = cur_line + 1'b1;
            cur_col = '0;
        end else begin
            cur_col = cur_col + 1'b1;
        end
        if (eot) begin
            if (scan != MODE_IDLE) begin
                res[n] = close_token();
                n++;
            end
            cur_off = '0;
            cur_line = '0;
            cur_col = '0;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) tokens_due.push_back(res[i]);
    endfunction

    function automatic void push_byte(logic [CH_W-1:0] c, logic eot);
        t_src_byte b;
        b.ch = c;
        b.eot = eot;
        byte_q.push_back(b);
        bytes_queued++;
    endfunction

    function automatic void push_text(string s, logic eot);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], eot && i == s.len() - 1);
    endfunction

    function automatic logic [CH_W-1:0] rand_letter();
        int k;
        k = $urandom_range(51);
        return CH_W'((k < 26) ? CH_UPPER_A + k : CH_LOWER_A + k - 26);
    endfunction

    function automatic logic [CH_W-1:0] rand_blank();
        case ($urandom_range(5))
            0: return CH_TAB;
            1: return CH_NEWLINE;
            2: return CH_VTAB;
            3: return CH_FORMFEED;
            4: return CH_RETURN;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic void push_random_text(int count);
        logic [CH_W-1:0] chunk[$];
        logic [CH_W-1:0] c;
        int start;
        int r;
        logic eot;
        start = bytes_queued;
        while (bytes_queued - start < count) begin
            chunk.delete();
            r = $urandom_range(99);
            eot = ($urandom_range(24) == 0);
            if (r < 30) begin
                chunk.push_back(rand_letter());
                repeat ($urandom_range(8)) begin
                    case ($urandom_range(2))
                        0: chunk.push_back(rand_letter());
                        1: chunk.push_back(CH_W'(CH_ZERO + $urandom_range(9)));
                        default: chunk.push_back(CH_UNDERSCORE);
                    endcase
                end
            end else if (r < 55) begin
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(2))
                        0: push_text("4294967295", 1'b0);
                        1: push_text("4294967296", 1'b0);
                        default: push_text("99999999999", 1'b0);
                    endcase
                end
                repeat ($urandom_range(1, 12))
                    chunk.push_back(CH_W'(CH_ZERO + $urandom_range(9)));
            end else if (r < 70) begin
                repeat ($urandom_range(1, 3)) chunk.push_back(rand_blank());
            end else if (r < 85) begin
                do c = CH_W'($urandom_range(255)); while (alpha_ch(c) || dec_ch(c) || blank_ch(c));
                chunk.push_back(c);
            end else begin
                chunk.push_back(CH_W'($urandom_range(255)));
            end
            if (r < 55 && $urandom_range(1) == 0) chunk.push_back(rand_blank());
            for (int i = 0; i < chunk.size(); i++)
                push_byte(chunk[i], eot && i == chunk.size() - 1);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : drive_input
        t_src_byte item;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) lex_byte(s_tdata, s_tlast);
            if (!s_tvalid || o_s_tready) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    item = byte_q.pop_front();
                    s_tdata <= item.ch;
                    s_tlast <= item.eot;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_output
        t_token want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (tokens_due.size() == 0) begin
                errors++;
                $display("%0t unexpected token transfer tdata %0h tuser %0h", $time,
                         o_m_tdata, o_m_tuser);
            end else begin
                want = tokens_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_m_tuser));
                check_field("value", want.value, o_m_tdata[0 +: VALUE_W]);
                check_field("offset", 32'(want.off), 32'(o_m_tdata[OFF_LO +: OB]));
                check_field("line", 32'(want.line), 32'(o_m_tdata[LINE_LO +: LB]));
                check_field("column", 32'(want.col), 32'(o_m_tdata[COL_LO +: CB]));
                check_field("length", 32'(want.len), 32'(o_m_tdata[LEN_LO +: LEN_W]));
                check_field("tlast", 32'(want.last), 32'(o_m_tlast));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        push_text("Az_9 ", 1'b0);
        push_text("09q+", 1'b0);
        push_text("5_", 1'b0);
        push_byte(CH_TAB, 1'b0);
        push_byte(CH_VTAB, 1'b0);
        push_byte(CH_FORMFEED, 1'b0);
        push_byte(CH_RETURN, 1'b0);
        push_byte(CH_NEWLINE, 1'b0);
        push_text("@[`{/:", 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("3z", 1'b1);
        push_text("Q", 1'b1);
        push_random_text(RANDOM_PER_PHASE);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk); while (byte_q.size() != 0 || s_tvalid);

        send_idle = 45;
        recv_idle = 21;
        push_random_text(RANDOM_PER_PHASE);
        do @(negedge i_clk); while (byte_q.size() != 0 || s_tvalid);

        send_idle = 0;
        recv_idle = 0;
        push_random_text(RANDOM_PER_PHASE);
        push_text(" 1+", 1'b1);
        push_text("x", 1'b1);
        push_text("k9", 1'b1);
        push_random_text(20);
        do @(negedge i_clk); while (byte_q.size() != 0 || s_tvalid);

        while (tokens_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && tokens_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/tin_pkg.sv
hw/rtl/tin_step.sv
hw/rtl/tin_outq.sv
hw/rtl/identifier_number_tokenizer_unit.sv
tb/testbench.sv
